/* hw/rtl/necir_pkg.sv */
// shared constants for the nec ir edge decoder
package necir_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned CfgW  = 20;
  localparam int unsigned CntW  = 6;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitsW = 32;
  // 23 * nominal fits in the config width plus five bits
  localparam int unsigned ProdW = CfgW + 5;

  localparam logic [CntW-1:0] FrameEdges = CntW'(34);

  localparam logic [IdxW-1:0] RegZeroSpace   = 2'd0;
  localparam logic [IdxW-1:0] RegOneSpace    = 2'd1;
  localparam logic [IdxW-1:0] RegRepeatSpace = 2'd2;
  localparam logic [IdxW-1:0] RegMaxSpace    = 2'd3;

  localparam logic [CfgW-1:0] ZeroSpaceRst   = CfgW'(1125);
  localparam logic [CfgW-1:0] OneSpaceRst    = CfgW'(2250);
  localparam logic [CfgW-1:0] RepeatSpaceRst = CfgW'(11250);
  localparam logic [CfgW-1:0] MaxSpaceRst    = CfgW'(15000);

  localparam logic [ByteW-1:0] ByteOnes = 8'hff;

endpackage

/* hw/rtl/necir_window.sv */
// plus or minus fifteen percent window test of a gap against a nominal space
module necir_window (
  input  logic [necir_pkg::CfgW-1:0] gap_i,
  input  logic [necir_pkg::CfgW-1:0] nominal_i,
  output logic                       hit_o
);

  logic [necir_pkg::ProdW-1:0] gap_x20;
  logic [necir_pkg::ProdW-1:0] nom_x17;
  logic [necir_pkg::ProdW-1:0] nom_x23;

  assign gap_x20 = {1'b0, gap_i, 4'b0} + {3'b0, gap_i, 2'b0};
  assign nom_x17 = {1'b0, nominal_i, 4'b0} + {5'b0, nominal_i};
  assign nom_x23 = {1'b0, nominal_i, 4'b0} + {3'b0, nominal_i, 2'b0}
                 + {4'b0, nominal_i, 1'b0} + {5'b0, nominal_i};

  assign hit_o = (gap_x20 > nom_x17) && (gap_x20 < nom_x23);

endmodule

/* hw/rtl/nec_ir_edge_decoder_unit.sv */
// NEC infrared remote decoder that takes one falling-edge timestamp per item.
// Each edge timestamp (microseconds, free running, 64 bits) is taken into an
// input register and handled from there once the result register can take its
// result: the gap to the previous edge is formed, checked against the restart
// limit, and classed against the repeat, zero and one windows (nominal +/-15%).
// A repeat code gives the last good address and command with is_repeat set;
// the closing edge of a clean frame whose address and command match their
// inverted copies gives a new result. One item is accepted per cycle while
// in_stall_o is low; an item's result, if any, is loaded into the result
// register when the item is handled. While a result waits under out_stall_i,
// the item behind it holds in the input register and the input stalls.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle; no logic enforces this.
module nec_ir_edge_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [necir_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [necir_pkg::CfgW-1:0]    cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [necir_pkg::TimeW-1:0]   edge_time_us_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [necir_pkg::ByteW-1:0]   ir_address_o,
  output logic [necir_pkg::ByteW-1:0]   ir_command_o,
  output logic                          is_repeat_o
);

  logic [necir_pkg::CfgW-1:0] zero_sp_q, one_sp_q, rep_sp_q, max_sp_q;

  logic                        in_vld_q, in_vld_d;
  logic [necir_pkg::TimeW-1:0] in_time_q;

  logic [necir_pkg::TimeW-1:0] prev_q, prev_d;
  logic [necir_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [necir_pkg::BitsW-1:0] shift_q, shift_d;
  logic                        bad_q, bad_d;
  logic [necir_pkg::ByteW-1:0] held_adr_q, held_adr_d;
  logic [necir_pkg::ByteW-1:0] held_cmd_q, held_cmd_d;

  logic                        out_vld_q, out_vld_d;
  logic [necir_pkg::ByteW-1:0] out_adr_q, out_adr_d;
  logic [necir_pkg::ByteW-1:0] out_cmd_q, out_cmd_d;
  logic                        out_rep_q, out_rep_d;

  logic                        adv;
  logic                        accept;
  logic [necir_pkg::TimeW-1:0] gap;
  logic                        over;
  logic                        rep_hit, zero_hit, one_hit;
  logic [necir_pkg::BitsW-1:0] shift_nx;
  logic                        bad_nx;
  logic [necir_pkg::ByteW-1:0] adr, inv_adr, cmd, inv_cmd;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign gap  = in_time_q - prev_q;
  assign over = gap > {{(necir_pkg::TimeW-necir_pkg::CfgW){1'b0}}, max_sp_q};

  necir_window u_rep_win (
    .gap_i     (gap[necir_pkg::CfgW-1:0]),
    .nominal_i (rep_sp_q),
    .hit_o     (rep_hit)
  );

  necir_window u_zero_win (
    .gap_i     (gap[necir_pkg::CfgW-1:0]),
    .nominal_i (zero_sp_q),
    .hit_o     (zero_hit)
  );

  necir_window u_one_win (
    .gap_i     (gap[necir_pkg::CfgW-1:0]),
    .nominal_i (one_sp_q),
    .hit_o     (one_hit)
  );

  always_comb begin
    shift_nx = shift_q;
    bad_nx   = bad_q;
    if (zero_hit) begin
      shift_nx = {1'b0, shift_q[necir_pkg::BitsW-1:1]};
    end else if (one_hit) begin
      shift_nx = {1'b1, shift_q[necir_pkg::BitsW-1:1]};
    end else begin
      bad_nx = 1'b1;
    end
  end

  assign adr     = shift_nx[7:0];
  assign inv_adr = shift_nx[15:8];
  assign cmd     = shift_nx[23:16];
  assign inv_cmd = shift_nx[31:24];

  always_comb begin
    in_vld_d   = in_vld_q;
    prev_d     = prev_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    bad_d      = bad_q;
    held_adr_d = held_adr_q;
    held_cmd_d = held_cmd_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_adr_d  = out_adr_q;
    out_cmd_d  = out_cmd_q;
    out_rep_d  = out_rep_q;

    if (adv) begin
      in_vld_d = 1'b0;
    end
    if (accept) begin
      in_vld_d = 1'b1;
    end

    if (adv) begin
      if (cnt_q == '0 || over) begin
        prev_d  = in_time_q;
        cnt_d   = necir_pkg::CntW'(1);
        shift_d = '0;
        bad_d   = 1'b0;
      end else if (cnt_q == necir_pkg::CntW'(1)) begin
        prev_d = in_time_q;
        if (rep_hit) begin
          shift_d   = '0;
          bad_d     = 1'b0;
          out_vld_d = 1'b1;
          out_adr_d = held_adr_q;
          out_cmd_d = held_cmd_q;
          out_rep_d = 1'b1;
        end else begin
          cnt_d = necir_pkg::CntW'(2);
        end
      end else begin
        prev_d  = in_time_q;
        cnt_d   = cnt_q + necir_pkg::CntW'(1);
        shift_d = shift_nx;
        bad_d   = bad_nx;
        if (cnt_q == necir_pkg::FrameEdges - necir_pkg::CntW'(1)) begin
          cnt_d   = '0;
          shift_d = '0;
          bad_d   = 1'b0;
          if (!bad_nx && adr == (inv_adr ^ necir_pkg::ByteOnes)
              && cmd == (inv_cmd ^ necir_pkg::ByteOnes)) begin
            held_adr_d = adr;
            held_cmd_d = cmd;
            out_vld_d  = 1'b1;
            out_adr_d  = adr;
            out_cmd_d  = cmd;
            out_rep_d  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_sp_q <= necir_pkg::ZeroSpaceRst;
      one_sp_q  <= necir_pkg::OneSpaceRst;
      rep_sp_q  <= necir_pkg::RepeatSpaceRst;
      max_sp_q  <= necir_pkg::MaxSpaceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        necir_pkg::RegZeroSpace:   zero_sp_q <= cfg_data_i;
        necir_pkg::RegOneSpace:    one_sp_q  <= cfg_data_i;
        necir_pkg::RegRepeatSpace: rep_sp_q  <= cfg_data_i;
        necir_pkg::RegMaxSpace:    max_sp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prev_q     <= '0;
      cnt_q      <= '0;
      shift_q    <= '0;
      bad_q      <= 1'b0;
      held_adr_q <= '0;
      held_cmd_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      prev_q     <= prev_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      bad_q      <= bad_d;
      held_adr_q <= held_adr_d;
      held_cmd_q <= held_cmd_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_time_q <= edge_time_us_i;
    end
    out_adr_q <= out_adr_d;
    out_cmd_q <= out_cmd_d;
    out_rep_q <= out_rep_d;
  end

  assign out_valid_o  = out_vld_q;
  assign ir_address_o = out_adr_q;
  assign ir_command_o = out_cmd_q;
  assign is_repeat_o  = out_rep_q;

endmodule

/* sim/tb.sv */
// self-checking testbench for the nec ir edge decoder unit
module tb;
  import necir_pkg::*;

  localparam int unsigned NumRegs    = 1 << IdxW;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] command;
    logic             rep;
  } ir_code_t;

  class ir_code_board;
    logic [CfgW-1:0]  space_reg [NumRegs];
    logic [TimeW-1:0] last_edge;
    logic [CntW-1:0]  edge_cnt;
    logic [BitsW-1:0] shift_bits;
    bit               bad_frame;
    logic [ByteW-1:0] held_adr;
    logic [ByteW-1:0] held_cmd;
    ir_code_t         pending_codes[$];
    int unsigned      codes_expected;
    int unsigned      codes_checked;
    int unsigned      repeats_checked;
    int unsigned      mismatches;

    function new();
      space_reg[RegZeroSpace]   = ZeroSpaceRst;
      space_reg[RegOneSpace]    = OneSpaceRst;
      space_reg[RegRepeatSpace] = RepeatSpaceRst;
      space_reg[RegMaxSpace]    = MaxSpaceRst;
      last_edge  = '0;
      edge_cnt   = '0;
      shift_bits = '0;
      bad_frame  = 1'b0;
      held_adr   = '0;
      held_cmd   = '0;
    endfunction

    // strict +-15% window around the nominal gap
    static function bit in_band(logic [TimeW-1:0] gap, logic [CfgW-1:0] nominal);
      logic [TimeW-1:0] span;
      span = TimeW'(nominal);
      return (gap * 20) > (span * 17) && (gap * 20) < (span * 23);
    endfunction

    function void begin_frame(logic [TimeW-1:0] t);
      edge_cnt   = CntW'(1);
      shift_bits = '0;
      bad_frame  = 1'b0;
      last_edge  = t;
    endfunction

    function void decode_edge(logic [TimeW-1:0] t);
      logic [TimeW-1:0] gap;
      bit               good;
      if (edge_cnt == 0) begin
        begin_frame(t);
        return;
      end
      gap = t - last_edge;
      if (gap > TimeW'(space_reg[RegMaxSpace])) begin
        begin_frame(t);
        return;
      end
      if (edge_cnt == 1) begin
        if (in_band(gap, space_reg[RegRepeatSpace])) begin
          begin_frame(t);
          pending_codes.push_back('{held_adr, held_cmd, 1'b1});
          codes_expected++;
          return;
        end
        last_edge = t;
        edge_cnt  = CntW'(2);
        return;
      end
      if (in_band(gap, space_reg[RegZeroSpace])) begin
        shift_bits = {1'b0, shift_bits[BitsW-1:1]};
      end else if (in_band(gap, space_reg[RegOneSpace])) begin
        shift_bits = {1'b1, shift_bits[BitsW-1:1]};
      end else begin
        bad_frame = 1'b1;
      end
      last_edge = t;
      edge_cnt++;
      if (edge_cnt >= FrameEdges) begin
        good = !bad_frame && shift_bits[7:0] == (shift_bits[15:8] ^ ByteOnes) &&
               shift_bits[23:16] == (shift_bits[31:24] ^ ByteOnes);
        if (good) begin
          held_adr = shift_bits[7:0];
          held_cmd = shift_bits[23:16];
          pending_codes.push_back('{held_adr, held_cmd, 1'b0});
          codes_expected++;
        end
        edge_cnt   = '0;
        shift_bits = '0;
        bad_frame  = 1'b0;
      end
    endfunction

    function void compare_code(logic [ByteW-1:0] adr, logic [ByteW-1:0] cmd, logic rep);
      ir_code_t want;
      codes_checked++;
      if (rep) repeats_checked++;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: adr %02h cmd %02h rep %0b", adr, cmd, rep);
        return;
      end
      want = pending_codes.pop_front();
      if (want.address !== adr || want.command !== cmd || want.rep !== rep) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want adr %02h cmd %02h rep %0b, got adr %02h cmd %02h rep %0b",
                   want.address, want.command, want.rep, adr, cmd, rep);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IdxW-1:0]     cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [TimeW-1:0]    edge_time_us_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ByteW-1:0]    ir_address_o;
  logic [ByteW-1:0]    ir_command_o;
  logic                is_repeat_o;

  ir_code_board        board;
  logic [TimeW-1:0]    clock_us;
  int unsigned         edges_sent;
  int unsigned         burst_left;
  int unsigned         settings_used;
  int unsigned         cycles_run;
  bit                  gaps_on;
  int unsigned         stall_left;
  int unsigned         stall_mode;
  logic [7:0]          stall_pattern;

  nec_ir_edge_decoder_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (cycles_run = 0; cycles_run < CycleLimit; cycles_run++) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stall in modes of random length
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode    = $urandom_range(0, 3);
      stall_left    = $urandom_range(50, 300);
      stall_pattern = 8'($urandom);
    end
    stall_left--;
    stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= stall_pattern[0];
      default: out_stall_i <= ($urandom_range(0, 9) < 6);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.compare_code(ir_address_o, ir_command_o, is_repeat_o);
  end

  task automatic send_edge(input logic [TimeW-1:0] t);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i     <= 1'b1;
    edge_time_us_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.decode_edge(t);
    if (burst_left > 0) burst_left--;
    edges_sent++;
    clock_us = t;
  endtask

  task automatic step(input logic [TimeW-1:0] gap);
    send_edge(clock_us + gap);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_space(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    board.space_reg[idx] = value;
  endtask

  task automatic apply_setting(input logic [CfgW-1:0] zero_us, input logic [CfgW-1:0] one_us,
                               input logic [CfgW-1:0] rep_us, input logic [CfgW-1:0] max_us);
    drain();
    write_space(RegZeroSpace, zero_us);
    write_space(RegOneSpace, one_us);
    write_space(RegRepeatSpace, rep_us);
    write_space(RegMaxSpace, max_us);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [TimeW-1:0] pick_in_band(logic [CfgW-1:0] nominal);
    int unsigned lo;
    int unsigned hi;
    if (nominal == 0) return '0;
    lo = (17 * nominal) / 20 + 1;
    hi = (23 * nominal - 1) / 20;
    return TimeW'($urandom_range(hi, lo));
  endfunction

  // gaps near window borders, the restart limit and anywhere at all
  function automatic logic [TimeW-1:0] odd_gap();
    logic [CfgW-1:0] nom;
    logic [TimeW-1:0] top;
    nom = board.space_reg[$urandom_range(0, NumRegs - 1)];
    top = TimeW'(board.space_reg[RegMaxSpace]);
    case ($urandom_range(0, 8))
      0: return '0;
      1: return TimeW'((17 * nom) / 20);
      2: return TimeW'((17 * nom + 19) / 20);
      3: return TimeW'((23 * nom) / 20);
      4: return TimeW'((23 * nom + 19) / 20);
      5: return top;
      6: return top + 1;
      7: return {$urandom, $urandom};
      default: return TimeW'($urandom_range(0, 32'(top)));
    endcase
  endfunction

  task automatic restart();
    logic [CfgW-1:0] top;
    top = board.space_reg[RegMaxSpace];
    if ($urandom_range(0, 4) == 0) step(TimeW'($urandom_range(0, 32'(top))));
    else step(TimeW'(top) + 1 + TimeW'($urandom_range(0, 5000)));
  endtask

  // flaw: 0 clean, 1 checksum broken, 2 one gap off, 3 cut short
  task automatic send_frame(input logic [ByteW-1:0] adr, input logic [ByteW-1:0] cmd,
                            input int unsigned flaw);
    logic [BitsW-1:0] word;
    logic [TimeW-1:0] gap;
    int unsigned      flaw_at;
    word    = {~cmd, cmd, ~adr, adr};
    flaw_at = $urandom_range(0, BitsW - 1);
    if (flaw == 1) word = word ^ (BitsW'(1) << $urandom_range(0, BitsW - 1));
    restart();
    gap = '0;
    repeat (8) begin
      gap = TimeW'($urandom_range(0, 32'(board.space_reg[RegMaxSpace])));
      if (!ir_code_board::in_band(gap, board.space_reg[RegRepeatSpace])) break;
      gap = '0;
    end
    step(gap);
    for (int i = 0; i < BitsW; i++) begin
      if (flaw == 3 && i == flaw_at) return;
      gap = word[i] ? pick_in_band(board.space_reg[RegOneSpace])
                    : pick_in_band(board.space_reg[RegZeroSpace]);
      if (flaw == 2 && i == flaw_at) gap = odd_gap();
      step(gap);
    end
  endtask

  task automatic random_traffic(input int unsigned items_goal, input int unsigned codes_goal);
    int unsigned first_item;
    int unsigned first_code;
    int unsigned kind;
    int unsigned rounds;
    first_item = edges_sent;
    first_code = board.codes_expected;
    rounds     = 0;
    while (edges_sent - first_item < items_goal ||
           board.codes_expected - first_code < codes_goal) begin
      rounds++;
      if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
      if (rounds % 25 == 12) drain();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_frame(8'($urandom), 8'($urandom), 0);
      end else if (kind < 55) begin
        send_frame(8'($urandom), 8'($urandom), $urandom_range(1, 3));
      end else if (kind < 80) begin
        restart();
        repeat ($urandom_range(1, 3)) step(pick_in_band(board.space_reg[RegRepeatSpace]));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) send_edge({$urandom, $urandom});
          else step(odd_gap());
        end
      end
    end
  endtask

  task automatic directed_edges();
    send_edge(64'hffff_ffff_ffff_f000);
    step(11250);
    step(9562);
    step(15001);
    step(9563);
    step(12937);
    step(12938);
    step(0);
    step(15000);
    send_edge('0);
    send_edge('1);
    step(15000);
    step(956);
    step(957);
    step(1293);
    step(1294);
    step(1913);
    step(2587);
    step(2588);
  endtask

  initial begin
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = RegZeroSpace;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    edge_time_us_i = '0;
    out_stall_i    = 1'b0;
    stall_left     = 0;
    gaps_on        = 1'b1;
    burst_left     = 0;
    edges_sent     = 0;
    settings_used  = 1;
    clock_us       = {$urandom, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_edges();
    random_traffic(700, 40);
    apply_setting(560, 1120, 5625, 7500);
    random_traffic(150, 0);
    // overlapping bit windows, the zero class takes the shared range
    apply_setting(1000, 1100, 20000, 30000);
    random_traffic(150, 0);
    apply_setting('0, '0, '0, '0);
    random_traffic(60, 0);
    apply_setting('1, '1, '1, '1);
    random_traffic(120, 0);
    apply_setting(ZeroSpaceRst, OneSpaceRst, RepeatSpaceRst, MaxSpaceRst);
    random_traffic(150, 10);
    drain();

    $display("sent %0d edge items over %0d register settings in %0d cycles",
             edges_sent, settings_used, cycles_run);
    $display("checked %0d codes (%0d repeats), %0d mismatches",
             board.codes_checked, board.repeats_checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_codes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/necir_pkg.sv
hw/rtl/necir_window.sv
hw/rtl/nec_ir_edge_decoder_unit.sv
sim/tb.sv
